// ===== rtl/marching_squares_segments_top_assert.svh =====
// Assertion macros used by the checker file of the isoline segment block.
`ifndef MARCHING_SQUARES_SEGMENTS_TOP_ASSERT_SVH
`define MARCHING_SQUARES_SEGMENTS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, disabled in reset.
`define MSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, disabled in reset.
`define MSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mss_pkg.sv =====
// Package with the types, constants and tables of the isoline segment block.
`default_nettype none
package mss_pkg;

	localparam int MAX_COLS = 1024;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int CNT_W    = COL_W + 1;
	localparam int ROW_W    = 16;
	localparam int DATA_W   = 32;
	localparam int SMP_W    = DATA_W + 1;
	localparam int MAG_W    = DATA_W + 1;
	localparam int PROD_W   = 64;
	localparam int DCNT_W   = $clog2(PROD_W);
	localparam int COORD_W  = 52;
	localparam int SUM_W    = 66;
	localparam int IDX_W    = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_ISO, REG_COLS, REG_ROWS, REG_OX, REG_OY, REG_SX, REG_SY
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CELL, S_SETUP, S_MUL, S_DINIT, S_DIV, S_POST1, S_POST2, S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		EDGE_BOTTOM, EDGE_RIGHT, EDGE_TOP, EDGE_LEFT
	} edge_t;

	typedef struct packed {
		logic       load_in;
		logic       evaluate;
		logic       setup;
		logic       mul;
		logic       dinit;
		logic       dstep;
		logic       post1;
		logic       post2;
		logic       emit;
		logic       last;
		logic [1:0] ep;
	} cmd_t;

	typedef struct packed {
		logic [1:0] nseg;
		logic       div_done;
		logic       out_free;
	} sts_t;

	// Edge list per corner case, endpoint 0 in the low bits.
	localparam logic [7:0] SEG_TABLE [16] = '{
		8'h00, 8'h0E, 8'h09, 8'h0D, 8'h04, 8'h9C, 8'h08, 8'h0C,
		8'h03, 8'h08, 8'hB4, 8'h04, 8'h0D, 8'h09, 8'h0B, 8'h00
	};

	function automatic logic [1:0] seg_count(input logic [3:0] kase);
		logic [1:0] n;
		case (kase)
			4'd0, 4'd15: n = 2'd0;
			4'd5, 4'd10: n = 2'd2;
			default:     n = 2'd1;
		endcase
		return n;
	endfunction

	function automatic edge_t seg_edge(input logic [3:0] kase, input logic [1:0] ep);
		logic [7:0] row;
		row = SEG_TABLE[kase];
		return edge_t'(row[2*ep +: 2]);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
		lo = ~hi;
		if (v > hi) return hi[DATA_W-1:0];
		else if (v < lo) return lo[DATA_W-1:0];
		else return v[DATA_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mss_ctrl.sv =====
// Controller state machine that sequences cell setup, endpoint arithmetic and output.
`default_nettype none
module mss_ctrl import mss_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  sts_t      sts,
	output cmd_t      cmd
);

	state_t     state_q, state_d;
	logic [1:0] ep_q, ep_d;
	logic [1:0] nseg_q, nseg_d;
	logic       last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ep_q    <= '0;
			nseg_q  <= '0;
		end else begin
			state_q <= state_d;
			ep_q    <= ep_d;
			nseg_q  <= nseg_d;
		end
	end

	assign last = ep_q[1] || (nseg_q == 2'd1);

	always_comb begin
		state_d  = state_q;
		ep_d     = ep_q;
		nseg_d   = nseg_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.ep   = ep_q;
		cmd.last = last;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CELL;
				end
			end
			S_CELL: begin
				cmd.evaluate = 1'b1;
				nseg_d       = sts.nseg;
				ep_d         = '0;
				state_d      = (sts.nseg == 2'd0) ? S_IDLE : S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.dinit = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				cmd.dstep = 1'b1;
				if (sts.div_done) state_d = S_POST1;
			end
			S_POST1: begin
				cmd.post1 = 1'b1;
				state_d   = S_POST2;
			end
			S_POST2: begin
				cmd.post2 = 1'b1;
				if (!ep_q[0]) begin
					ep_d    = ep_q + 2'd1;
					state_d = S_SETUP;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (last) begin
						state_d = S_IDLE;
					end else begin
						ep_d    = ep_q + 2'd1;
						state_d = S_SETUP;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/mss_datapath.sv =====
// Datapath with configuration, line store, cell evaluation, divider and output register.
`default_nettype none
module mss_datapath import mss_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  cmd_t                          cmd,
	output sts_t                          sts,
	input  wire logic signed [DATA_W-1:0] sample,
	input  wire logic                     sample_invalid,
	input  wire logic                     cfg_valid,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [DATA_W-1:0]        cfg_data,
	input  wire logic                     out_ready,
	output logic                          out_valid,
	output logic signed [DATA_W-1:0]      x_start,
	output logic signed [DATA_W-1:0]      y_start,
	output logic signed [DATA_W-1:0]      x_end,
	output logic signed [DATA_W-1:0]      y_end,
	output logic                          last_segment
);

	logic signed [DATA_W-1:0] iso_q, ox_q, oy_q, sx_q, sy_q;
	logic [CNT_W-1:0]         gcols_q;
	logic [ROW_W-1:0]         grows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q   <= '0;
			gcols_q <= CNT_W'(2);
			grows_q <= ROW_W'(2);
			ox_q    <= '0;
			oy_q    <= '0;
			sx_q    <= DATA_W'(65536);
			sy_q    <= DATA_W'(65536);
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_ISO:  iso_q   <= cfg_data;
				REG_COLS: gcols_q <= cfg_data[CNT_W-1:0];
				REG_ROWS: grows_q <= cfg_data[ROW_W-1:0];
				REG_OX:   ox_q    <= cfg_data;
				REG_OY:   oy_q    <= cfg_data;
				REG_SX:   sx_q    <= cfg_data;
				REG_SY:   sy_q    <= cfg_data;
				default:  ;
			endcase
		end
	end

	// Line store and the transaction's sample.
	logic [SMP_W-1:0] row_mem [MAX_COLS];
	logic [SMP_W-1:0] above_q, cur_q;
	logic [SMP_W-1:0] left_q, upper_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			above_q <= row_mem[col_q];
			cur_q   <= {sample_invalid, sample};
		end
		if (cmd.evaluate) row_mem[col_q] <= cur_q;
	end

	logic [CNT_W-1:0] cols_eff;
	logic [ROW_W-1:0] rows_eff;

	always_comb begin
		if (gcols_q < CNT_W'(2)) cols_eff = CNT_W'(2);
		else if (gcols_q > CNT_W'(MAX_COLS)) cols_eff = CNT_W'(MAX_COLS);
		else cols_eff = gcols_q;
		rows_eff = (grows_q < ROW_W'(2)) ? ROW_W'(2) : grows_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			upper_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cmd.evaluate) begin
			upper_q <= above_q;
			left_q  <= cur_q;
			if ({1'b0, col_q} + CNT_W'(1) >= cols_eff) begin
				col_q <= '0;
				if ({1'b0, row_q} + (ROW_W+1)'(1) >= {1'b0, rows_eff}) row_q <= '0;
				else row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Cell evaluation.
	logic signed [DATA_W-1:0]  tl, tr, br, bl;
	logic [3:0]                kase;
	logic                      cell_ok;
	logic signed [COL_W+DATA_W:0] cxp;
	logic signed [ROW_W+DATA_W:0] cyp;
	logic [COL_W-1:0]          colm1;
	logic [ROW_W-1:0]          rowm1;

	assign tl      = upper_q[DATA_W-1:0];
	assign tr      = above_q[DATA_W-1:0];
	assign br      = cur_q[DATA_W-1:0];
	assign bl      = left_q[DATA_W-1:0];
	assign kase    = {bl >= iso_q, br >= iso_q, tr >= iso_q, tl >= iso_q};
	assign cell_ok = (row_q != '0) && (col_q != '0) &&
		!(upper_q[DATA_W] | above_q[DATA_W] | cur_q[DATA_W] | left_q[DATA_W]);
	assign colm1   = col_q - COL_W'(1);
	assign rowm1   = row_q - ROW_W'(1);
	assign cxp     = $signed({1'b0, colm1}) * sx_q;
	assign cyp     = $signed({1'b0, rowm1}) * sy_q;

	logic signed [DATA_W-1:0]  tl_q, tr_q, br_q, bl_q;
	logic [3:0]                kase_q;
	logic signed [COORD_W-1:0] cx_q, cy_q;

	always_ff @(posedge clk) begin
		if (cmd.evaluate) begin
			tl_q   <= tl;
			tr_q   <= tr;
			br_q   <= br;
			bl_q   <= bl;
			kase_q <= kase;
			cx_q   <= COORD_W'(ox_q) + COORD_W'(cxp);
			cy_q   <= COORD_W'(oy_q) + COORD_W'(cyp);
		end
	end

	// Endpoint setup.
	edge_t                     edge_sel;
	logic signed [DATA_W-1:0]  ea, eb, es;
	logic signed [COORD_W-1:0] cxs, cys;
	logic signed [COORD_W-1:0] base, e0, e1, fixed;
	logic                      sub, interp_x;
	logic signed [MAG_W-1:0]   n, d;

	assign edge_sel = seg_edge(kase_q, cmd.ep);
	assign cxs      = cx_q + COORD_W'(sx_q);
	assign cys      = cy_q + COORD_W'(sy_q);

	always_comb begin
		case (edge_sel)
			EDGE_BOTTOM: begin
				ea = bl_q; eb = br_q; es = sx_q;
				base = cx_q; sub = 1'b0; e0 = cx_q; e1 = cxs; fixed = cys; interp_x = 1'b1;
			end
			EDGE_RIGHT: begin
				ea = br_q; eb = tr_q; es = sy_q;
				base = cys; sub = 1'b1; e0 = cy_q; e1 = cys; fixed = cxs; interp_x = 1'b0;
			end
			EDGE_TOP: begin
				ea = tr_q; eb = tl_q; es = sx_q;
				base = cxs; sub = 1'b1; e0 = cx_q; e1 = cxs; fixed = cy_q; interp_x = 1'b1;
			end
			default: begin
				ea = tl_q; eb = bl_q; es = sy_q;
				base = cy_q; sub = 1'b0; e0 = cy_q; e1 = cys; fixed = cx_q; interp_x = 1'b0;
			end
		endcase
		n = MAG_W'(iso_q) - MAG_W'(ea);
		d = MAG_W'(eb) - MAG_W'(ea);
	end

	logic [MAG_W-1:0]          nmag_q, dmag_q;
	logic [DATA_W-1:0]         smag_q;
	logic                      neg_q, sub_q, interp_x_q;
	logic signed [COORD_W-1:0] base_q, e0_q, e1_q, fixed_q;
	logic [PROD_W-1:0]         prod_q, quo_q;
	logic [MAG_W-1:0]          rem_q;
	logic [DCNT_W-1:0]         dcnt_q;
	logic [MAG_W:0]            rem_sh;
	logic                      ge;
	logic [MAG_W:0]            rem_sub;

	assign rem_sh  = {rem_q, quo_q[PROD_W-1]};
	assign ge      = rem_sh >= {1'b0, dmag_q};
	assign rem_sub = rem_sh - {1'b0, dmag_q};

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			nmag_q     <= n[MAG_W-1] ? MAG_W'(-n) : MAG_W'(n);
			dmag_q     <= d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
			smag_q     <= es[DATA_W-1] ? DATA_W'(-es) : DATA_W'(es);
			neg_q      <= n[MAG_W-1] ^ d[MAG_W-1] ^ es[DATA_W-1];
			base_q     <= base;
			sub_q      <= sub;
			e0_q       <= e0;
			e1_q       <= e1;
			fixed_q    <= fixed;
			interp_x_q <= interp_x;
		end
		if (cmd.mul) prod_q <= PROD_W'(nmag_q) * PROD_W'(smag_q);
		if (cmd.dinit) begin
			quo_q  <= prod_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.dstep) begin
			quo_q  <= {quo_q[PROD_W-2:0], ge};
			rem_q  <= ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	// Offset sign, add to or subtract from the edge base, then clamp and saturate.
	logic [PROD_W-1:0]        q, qc;
	logic signed [SUM_W-1:0]  sc_pos, sc, base_ext, sum_q;
	logic signed [SUM_W-1:0]  e0x, e1x, lo, hi, cl;
	logic signed [DATA_W-1:0] ip, fp, px, py;
	logic signed [DATA_W-1:0] xs_q, ys_q, xe_q, ye_q;

	always_comb begin
		q        = (dmag_q == '0) ? '0 : quo_q;
		qc       = (q > (PROD_W'(1) << 62)) ? (PROD_W'(1) << 62) : q;
		sc_pos   = SUM_W'(qc);
		sc       = neg_q ? -sc_pos : sc_pos;
		base_ext = SUM_W'(base_q);
		e0x      = SUM_W'(e0_q);
		e1x      = SUM_W'(e1_q);
		lo       = (e0x < e1x) ? e0x : e1x;
		hi       = (e0x < e1x) ? e1x : e0x;
		cl       = (sum_q < lo) ? lo : ((sum_q > hi) ? hi : sum_q);
		ip       = sat32(cl);
		fp       = sat32(SUM_W'(fixed_q));
		px       = interp_x_q ? ip : fp;
		py       = interp_x_q ? fp : ip;
	end

	always_ff @(posedge clk) begin
		if (cmd.post1) sum_q <= sub_q ? base_ext - sc : base_ext + sc;
		if (cmd.post2) begin
			if (!cmd.ep[0]) begin
				xs_q <= px;
				ys_q <= py;
			end else begin
				xe_q <= px;
				ye_q <= py;
			end
		end
		if (cmd.emit) begin
			x_start      <= xs_q;
			y_start      <= ys_q;
			x_end        <= xe_q;
			y_end        <= ye_q;
			last_segment <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	assign sts.nseg     = cell_ok ? seg_count(kase) : 2'd0;
	assign sts.div_done = (dcnt_q == {DCNT_W{1'b1}});
	assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== rtl/marching_squares_segments_top.sv =====
// Top level of the streaming marching-squares isoline segment extractor.
//
//  Channel  Handshake             Payload
//  in       in_valid/in_ready     sample, sample_invalid
//  out      out_valid/out_ready   x_start, y_start, x_end, y_end, last_segment
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A sample whose cell yields no segment returns to idle after cell evaluation;
// else each of its one or two segments computes both endpoints and is then emitted.
// Each endpoint: setup, multiply, 64-bit one-bit-per-cycle divide, two post steps.
// The last segment waits in the output register while the next transaction is taken.
// The line store is not cleared by reset; its entries are undefined until written.
`default_nettype none
module marching_squares_segments_top import mss_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [DATA_W-1:0] sample,
	input  wire logic                     sample_invalid,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      x_start,
	output logic signed [DATA_W-1:0]      y_start,
	output logic signed [DATA_W-1:0]      x_end,
	output logic signed [DATA_W-1:0]      y_end,
	output logic                          last_segment,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [DATA_W-1:0]        cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mss_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.sample         (sample),
		.sample_invalid (sample_invalid),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.x_start        (x_start),
		.y_start        (y_start),
		.x_end          (x_end),
		.y_end          (y_end),
		.last_segment   (last_segment)
	);

endmodule
`default_nettype wire

// ===== rtl/mss_checker.sv =====
// Port-level checker for the isoline segment block and its bind statement.
`default_nettype none
`include "marching_squares_segments_top_assert.svh"
module mss_checker import mss_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic signed [DATA_W-1:0] x_start,
	input wire logic                     last_segment
);

	`MSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(x_start) && $stable(last_segment), "Stalled output transaction changed")
	`MSS_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready, "Input taken again in the cycle after a transaction")
	`MSS_ASSERT_NOW(a_no_early_out, $rose(out_valid), !$past(in_valid && in_ready), "Segment appeared directly after an input transaction")

endmodule

bind marching_squares_segments_top mss_checker u_mss_checker (.*);
`default_nettype wire
